// ----- rtl/core/pager_bit_transmitter_defines.svh -----
// Assertion macros used by the pager transmitter RTL.
`ifndef PAGER_BIT_TRANSMITTER_DEFINES_SVH
`define PAGER_BIT_TRANSMITTER_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define PBT_ASSERT_HOLD(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PBT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PBT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/pbt_pkg.sv -----
// Types and constants for the pager bit transmitter.
`default_nettype none

package pbt_pkg;

   localparam int BUFFER_BYTES_DEF = 1024;
   localparam int BYTE_BITS        = 8;
   localparam logic [15:0] PREAMBLE_LEN_RST = 16'd576;

   typedef enum logic [2:0] {
      OP_WRITE_BYTE = 3'd0,
      OP_START_MSG  = 3'd1,
      OP_START_TEST = 3'd2,
      OP_STOP       = 3'd3,
      OP_TICK       = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PREAMBLE = 3'd1,
      PH_DATA     = 3'd2,
      PH_STOP     = 3'd3,
      PH_TEST     = 3'd4
   } phase_type;

   typedef enum logic [7:0] {
      CSR_PREAMBLE_LEN = 8'd0,
      CSR_POLARITY     = 8'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      TP_ZERO = 2'd0,
      TP_ONE  = 2'd1,
      TP_ALT  = 2'd2,
      TP_ALT2 = 2'd3
   } test_pat_type;

   // Result word, line_level in bit 0.
   typedef struct packed {
      phase_type phase;
      logic      accepted;
      logic      radio_power_off;
      logic      busy_res;
      logic      line_level;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/pbt_byte_buf.sv -----
// Byte buffer: one write port, one registered read port with write bypass.
`default_nettype none

module pbt_byte_buf
   import pbt_pkg::*;
#(
   parameter int DEPTH = BUFFER_BYTES_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pager_bit_transmitter.sv -----
// Pager bit transmitter: command decode, bit sequencer and result skid buffer.
// Each result word is registered in the output register, or in the skid while rsp_ stalls.
// Throughput: one command word per cycle; a two-word output skid keeps req_ open
// for one extra word while rsp_ stalls.
// The buffer read port always holds the byte at the current pointer, read ahead from ptr_in.
// Reset (synchronous): sequencer idle, line low, preamble length 576, polarity 0;
// the byte buffer keeps its contents.
`default_nettype none
`include "pager_bit_transmitter_defines.svh"

module pager_bit_transmitter
   import pbt_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: byte_index[9:0], byte_value[17:10], byte_count[28:18], test_pattern[30:29]
   input  wire logic [31:0] req_tdata,
   // req_tuser: opcode[2:0]
   input  wire logic [2:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: line_level[0], busy_res[1], radio_power_off[2], accepted[3], phase[6:4]
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int AW = $clog2(BUFFER_BYTES);

   // configuration
   logic [15:0] preamble_len_ff;
   logic        polarity_ff;

   // sequencer state
   phase_type    phase_ff, phase_in;
   logic [15:0]  preamble_left_ff, preamble_left_in;
   logic [3:0]   bit_pos_ff, bit_pos_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [10:0]  bytes_left_ff, bytes_left_in;
   logic         next_bit_ff, next_bit_in;
   test_pat_type test_mode_ff, test_mode_in;
   logic         line_ff, line_in;

   // output skid
   logic    out_v_ff, skid_v_ff;
   rsp_type out_ff, skid_ff;
   rsp_type rsp_new;

   logic        acc;
   op_type      op;
   logic [9:0]  f_index;
   logic [7:0]  f_value;
   logic [10:0] f_count;
   logic [1:0]  f_pattern;
   logic [16:0] idx_ext;
   logic        idx_ok;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]  rd_byte;
   logic [AW:0] ptr_plus;
   logic [3:0]  pos_plus;
   logic        res_accepted, res_off;

   assign req_tready = !reset && !skid_v_ff;
   assign csr_ready  = !reset;
   assign acc        = req_tvalid && req_tready;

   assign op        = op_type'(req_tuser);
   assign f_index   = req_tdata[9:0];
   assign f_value   = req_tdata[17:10];
   assign f_count   = req_tdata[28:18];
   assign f_pattern = req_tdata[30:29];

   assign idx_ext  = 17'(f_index);
   assign idx_ok   = idx_ext < 17'(BUFFER_BYTES);
   assign wr_addr  = idx_ext[AW-1:0];
   assign ptr_plus = {1'b0, ptr_ff} + (AW+1)'(1);
   assign pos_plus = bit_pos_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_len_ff <= PREAMBLE_LEN_RST;
         polarity_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PREAMBLE_LEN: preamble_len_ff <= csr_data;
            CSR_POLARITY:     polarity_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      preamble_left_in = preamble_left_ff;
      bit_pos_in       = bit_pos_ff;
      ptr_in           = ptr_ff;
      bytes_left_in    = bytes_left_ff;
      next_bit_in      = next_bit_ff;
      test_mode_in     = test_mode_ff;
      line_in          = line_ff;
      res_accepted     = 1'b0;
      res_off          = 1'b0;
      wr_en            = 1'b0;
      if (acc) begin
         unique case (op)
            OP_WRITE_BYTE: begin
               if (idx_ok) begin
                  wr_en        = 1'b1;
                  res_accepted = 1'b1;
               end
            end
            OP_START_MSG: begin
               if (phase_ff == PH_IDLE && f_count != 11'd0) begin
                  next_bit_in      = 1'b0;
                  line_in          = 1'b0;
                  bytes_left_in    = f_count;
                  preamble_left_in = preamble_len_ff;
                  phase_in         = PH_PREAMBLE;
                  res_accepted     = 1'b1;
               end
            end
            OP_START_TEST: begin
               if (phase_ff == PH_IDLE) begin
                  next_bit_in  = 1'b0;
                  line_in      = 1'b0;
                  test_mode_in = test_pat_type'(f_pattern);
                  phase_in     = PH_TEST;
                  res_accepted = 1'b1;
               end
            end
            OP_STOP: begin
               line_in      = 1'b0;
               res_off      = 1'b1;
               phase_in     = PH_IDLE;
               res_accepted = 1'b1;
            end
            OP_TICK: begin
               res_accepted = 1'b1;
               line_in      = polarity_ff ? next_bit_ff : !next_bit_ff;
               unique case (phase_ff)
                  PH_PREAMBLE: begin
                     next_bit_in      = !next_bit_ff;
                     preamble_left_in = preamble_left_ff - 16'd1;
                     if (preamble_left_in == 16'd0) begin
                        phase_in   = PH_DATA;
                        bit_pos_in = 4'd0;
                        ptr_in     = '0;
                     end
                  end
                  PH_DATA: begin
                     next_bit_in = rd_byte[~bit_pos_ff[2:0]];
                     bit_pos_in  = pos_plus;
                     if (pos_plus >= 4'(BYTE_BITS)) begin
                        bit_pos_in    = 4'd0;
                        bytes_left_in = bytes_left_ff - 11'd1;
                        if (bytes_left_in == 11'd0) begin
                           phase_in = PH_STOP;
                        end else if (ptr_plus >= (AW+1)'(BUFFER_BYTES)) begin
                           ptr_in = '0;
                        end else begin
                           ptr_in = ptr_plus[AW-1:0];
                        end
                     end
                  end
                  PH_STOP: begin
                     bit_pos_in = pos_plus;
                     if (pos_plus > 4'd1) begin
                        next_bit_in = 1'b0;
                        line_in     = 1'b0;
                        res_off     = 1'b1;
                        phase_in    = PH_IDLE;
                        bit_pos_in  = 4'd0;
                     end
                  end
                  PH_TEST: begin
                     case (test_mode_ff)
                        TP_ZERO: next_bit_in = 1'b0;
                        TP_ONE:  next_bit_in = 1'b1;
                        default: next_bit_in = !next_bit_ff;
                     endcase
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_new.phase           = phase_in;
      rsp_new.accepted        = res_accepted;
      rsp_new.radio_power_off = res_off;
      rsp_new.busy_res        = phase_in != PH_IDLE;
      rsp_new.line_level      = line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         preamble_left_ff <= '0;
         bit_pos_ff       <= '0;
         ptr_ff           <= '0;
         bytes_left_ff    <= '0;
         next_bit_ff      <= 1'b0;
         test_mode_ff     <= TP_ZERO;
         line_ff          <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         preamble_left_ff <= preamble_left_in;
         bit_pos_ff       <= bit_pos_in;
         ptr_ff           <= ptr_in;
         bytes_left_ff    <= bytes_left_in;
         next_bit_ff      <= next_bit_in;
         test_mode_ff     <= test_mode_in;
         line_ff          <= line_in;
      end
   end

   pbt_byte_buf #(
      .DEPTH (BUFFER_BYTES)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (f_value),
      .rd_addr (ptr_in),
      .rd_data (rd_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff  <= skid_v_ff || acc;
         skid_v_ff <= 1'b0;
      end else if (acc) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= skid_v_ff ? skid_ff : rsp_new;
      end
      if (acc && out_v_ff && !rsp_tready) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, out_ff};

   `PBT_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff,
      "skid word held with empty output register")
   `PBT_ASSERT_NXT(a_stall_fills_skid, clock, reset, acc && out_v_ff && !rsp_tready, skid_v_ff,
      "word taken during stall not captured")
   `PBT_ASSERT_IMP(a_off_ends_idle, clock, reset, out_v_ff && out_ff.radio_power_off,
      out_ff.phase == PH_IDLE && !out_ff.line_level, "power-off word not idle with line low")
   `PBT_ASSERT_IMP(a_busy_matches_phase, clock, reset, out_v_ff,
      out_ff.busy_res == (out_ff.phase != PH_IDLE), "busy flag disagrees with phase")
   `PBT_ASSERT_IMP(a_data_pos_range, clock, reset, phase_ff == PH_DATA, !bit_pos_ff[3],
      "bit position past end of byte in data phase")

endmodule

`default_nettype wire

// ----- tb/sv/tb_pager_bit_transmitter.sv -----
// Self-checking testbench for pager_bit_transmitter: result words checked against a bit predictor.
`timescale 1ns / 1ps

module tb_pager_bit_transmitter;
   import pbt_pkg::*;

   localparam int SEND_GAP_MAX = 30;
   localparam int STALL_MAX    = 30;
   localparam int STORE_LAST   = BUFFER_BYTES_DEF - 1;
   localparam logic [2:0] OP_CODE_MAX = 3'b111;

   typedef struct {
      logic [2:0]  opcode;
      logic [9:0]  byte_index;
      logic [7:0]  byte_value;
      logic [10:0] byte_count;
      logic [1:0]  test_pattern;
   } tx_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   pager_bit_transmitter dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // transmitter state as the predictor sees it
   logic [15:0] cfg_preamble_len = PREAMBLE_LEN_RST;
   logic        cfg_polarity = 1'b0;
   phase_type   tx_phase = PH_IDLE;
   logic [15:0] preamble_left = '0;
   logic [3:0]  bit_pos = '0;
   logic [9:0]  byte_ptr = '0;
   logic [10:0] bytes_left = '0;
   logic        pending_bit = 1'b0;
   logic [1:0]  pattern_mode = '0;
   logic        line_q = 1'b0;
   logic [7:0]  byte_mem [BUFFER_BYTES_DEF];

   rsp_type    expected_status[$];
   tx_cmd_type cmd_queue[$];
   tx_cmd_type cmd_on_bus;
   int      cmd_total = 0;
   int      rsp_count = 0;
   int      error_count = 0;
   int      send_gap = 0;
   int      send_quiet = 0;
   int      stall_left = 0;
   int      stall_quiet = 0;
   int      hold_left = 0;
   longint  cycle_count = 0;
   bit      filled [BUFFER_BYTES_DEF];
   int      fill_prefix = 0;

   function automatic rsp_type predict_status(tx_cmd_type c);
      rsp_type r;
      logic [7:0] b;
      r = '0;
      case (c.opcode)
         OP_WRITE_BYTE: begin
            byte_mem[c.byte_index] = c.byte_value;
            r.accepted = 1'b1;
         end
         OP_START_MSG: begin
            if (tx_phase == PH_IDLE && c.byte_count != '0) begin
               pending_bit = 1'b0;
               line_q = 1'b0;
               bytes_left = c.byte_count;
               preamble_left = cfg_preamble_len;
               tx_phase = PH_PREAMBLE;
               r.accepted = 1'b1;
            end
         end
         OP_START_TEST: begin
            if (tx_phase == PH_IDLE) begin
               pending_bit = 1'b0;
               line_q = 1'b0;
               pattern_mode = c.test_pattern;
               tx_phase = PH_TEST;
               r.accepted = 1'b1;
            end
         end
         OP_STOP: begin
            line_q = 1'b0;
            r.radio_power_off = 1'b1;
            tx_phase = PH_IDLE;
            r.accepted = 1'b1;
         end
         OP_TICK: begin
            r.accepted = 1'b1;
            line_q = cfg_polarity ? pending_bit : ~pending_bit;
            case (tx_phase)
               PH_PREAMBLE: begin
                  pending_bit = ~pending_bit;
                  preamble_left = preamble_left - 16'd1;
                  if (preamble_left == '0) begin
                     tx_phase = PH_DATA;
                     bit_pos = '0;
                     byte_ptr = '0;
                  end
               end
               PH_DATA: begin
                  b = byte_mem[byte_ptr];
                  pending_bit = b[3'd7 - bit_pos[2:0]];
                  bit_pos = bit_pos + 4'd1;
                  if (bit_pos >= 4'd8) begin
                     bit_pos = '0;
                     bytes_left = bytes_left - 11'd1;
                     if (bytes_left == '0) tx_phase = PH_STOP;
                     else byte_ptr = (byte_ptr == STORE_LAST) ? '0 : byte_ptr + 10'd1;
                  end
               end
               PH_STOP: begin
                  bit_pos = bit_pos + 4'd1;
                  if (bit_pos > 4'd1) begin
                     pending_bit = 1'b0;
                     line_q = 1'b0;
                     r.radio_power_off = 1'b1;
                     tx_phase = PH_IDLE;
                     bit_pos = '0;
                  end
               end
               PH_TEST: begin
                  if (pattern_mode == TP_ZERO) pending_bit = 1'b0;
                  else if (pattern_mode == TP_ONE) pending_bit = 1'b1;
                  else pending_bit = ~pending_bit;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.line_level = line_q;
      r.busy_res = (tx_phase != PH_IDLE);
      r.phase = tx_phase;
      return r;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones, and quiet stretches
   function automatic int idle_len(inout int quiet, input int longest);
      int roll;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      roll = $urandom_range(0, 199);
      if (roll < 2) begin
         quiet = $urandom_range(50, 300);
         return 0;
      end
      if (roll < 120) return 0;
      if (roll < 188) return $urandom_range(1, 3);
      return $urandom_range(8, longest);
   endfunction

   // sender
   always @(posedge clock) begin
      logic bus_free;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         bus_free = !req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_status.push_back(predict_status(cmd_on_bus));
            bus_free = 1'b1;
         end
         if (bus_free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               cmd_on_bus = cmd_queue.pop_front();
               req_tdata <= {1'b0, cmd_on_bus.test_pattern, cmd_on_bus.byte_count,
                             cmd_on_bus.byte_value, cmd_on_bus.byte_index};
               req_tuser <= cmd_on_bus.opcode;
               req_tvalid <= 1'b1;
               send_gap = idle_len(send_quiet, SEND_GAP_MAX);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      rsp_type got, want;
      logic ready_next;
      if (!reset) begin
         ready_next = 1'b1;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[6:0]);
            rsp_count++;
            if (expected_status.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result word %0d: %h", rsp_count, rsp_tdata);
            end else begin
               want = expected_status.pop_front();
               if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
                   got.radio_power_off !== want.radio_power_off ||
                   got.accepted !== want.accepted || got.phase !== want.phase) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"word %0d: expected line=%0b busy=%0b off=%0b acc=%0b phase=%0d,",
                               " got line=%0b busy=%0b off=%0b acc=%0b phase=%0d"},
                              rsp_count, want.line_level, want.busy_res,
                              want.radio_power_off, want.accepted, want.phase,
                              got.line_level, got.busy_res, got.radio_power_off,
                              got.accepted, got.phase);
               end
            end
            stall_left = idle_len(stall_quiet, STALL_MAX);
            // long back-pressure so the skid fills and req_tready drops
            if (rsp_count % 3000 == 500) hold_left = $urandom_range(150, 400);
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 200000 + longint'(cmd_total) * 4 * (SEND_GAP_MAX + STALL_MAX + 2)) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void push_cmd(tx_cmd_type c);
      cmd_queue.push_back(c);
      cmd_total++;
      if (c.opcode == OP_WRITE_BYTE) begin
         filled[c.byte_index] = 1'b1;
         while (fill_prefix < BUFFER_BYTES_DEF && filled[fill_prefix]) fill_prefix++;
      end
   endfunction

   // start counts stay within the written head of the store
   function automatic tx_cmd_type make_cmd(logic [2:0] op);
      tx_cmd_type c;
      int most;
      c.opcode = op;
      c.byte_index = 10'($urandom);
      c.byte_value = 8'($urandom);
      c.byte_count = 11'($urandom);
      c.test_pattern = 2'($urandom);
      if (op == OP_START_MSG) begin
         most = (fill_prefix < 4) ? fill_prefix : 4;
         c.byte_count = (most == 0 || $urandom_range(0, 19) == 0) ?
                        11'd0 : 11'($urandom_range(1, most));
      end
      return c;
   endfunction

   function automatic void push_op(logic [2:0] op);
      push_cmd(make_cmd(op));
   endfunction

   function automatic void push_write(logic [9:0] idx, logic [7:0] val);
      tx_cmd_type c;
      c = make_cmd(OP_WRITE_BYTE);
      c.byte_index = idx;
      c.byte_value = val;
      push_cmd(c);
   endfunction

   function automatic logic [2:0] noise_op();
      case ($urandom_range(0, 3))
         0: return OP_WRITE_BYTE;
         1: return OP_START_MSG;
         2: return OP_START_TEST;
         default: return 3'($urandom_range(OP_TICK + 1, OP_CODE_MAX));
      endcase
   endfunction

   function automatic void push_ticks(int n, int noise_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < noise_pct) push_cmd(make_cmd(noise_op()));
         push_op(OP_TICK);
      end
   endfunction

   function automatic void add_traffic(int amount);
      int stop_at = cmd_total + amount;
      int roll;
      int span;
      tx_cmd_type c;
      while (cmd_total < stop_at) begin
         if (fill_prefix < BUFFER_BYTES_DEF && $urandom_range(0, 3) == 0)
            for (int i = 0; i < 8 && fill_prefix < BUFFER_BYTES_DEF; i++)
               push_write(10'(fill_prefix), 8'($urandom));
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            c = make_cmd(OP_START_MSG);
            push_cmd(c);
            span = int'(cfg_preamble_len) + 8 * int'(c.byte_count) + 2 + $urandom_range(0, 2);
            if ($urandom_range(0, 6) == 0) begin
               push_ticks($urandom_range(1, span), 8);
               push_op(OP_STOP);
            end else begin
               push_ticks(span, 8);
            end
         end else if (roll < 80) begin
            push_op(OP_START_TEST);
            push_ticks($urandom_range(1, 12), 8);
            push_op(OP_STOP);
         end else begin
            repeat ($urandom_range(1, 5)) push_op(3'($urandom_range(0, OP_CODE_MAX)));
         end
      end
   endfunction

   task automatic write_csr(csr_idx_type idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_PREAMBLE_LEN) cfg_preamble_len = val;
      else cfg_polarity = val[0];
   endtask

   task automatic wait_drained();
      while (rsp_count < cmd_total) @(posedge clock);
   endtask

   initial begin
      tx_cmd_type c;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      push_op(OP_TICK);
      push_write(10'd0, 8'hFF);
      push_write(10'(STORE_LAST), 8'h00);
      push_write(10'd1, 8'h5A);
      push_op(OP_CODE_MAX);
      c = make_cmd(OP_START_MSG);
      c.byte_count = '0;
      push_cmd(c);
      push_op(OP_STOP);
      c = make_cmd(OP_START_TEST);
      c.test_pattern = TP_ZERO;
      push_cmd(c);
      push_op(OP_TICK);
      push_op(OP_START_MSG);
      push_op(OP_START_TEST);
      push_op(OP_TICK);
      push_op(OP_STOP);
      for (int p = TP_ONE; p <= TP_ALT2; p++) begin
         c = make_cmd(OP_START_TEST);
         c.test_pattern = 2'(p);
         push_cmd(c);
         push_ticks(3, 0);
         push_op(OP_STOP);
      end
      c = make_cmd(OP_START_MSG);
      c.byte_count = 11'd2;
      push_cmd(c);
      push_ticks(int'(cfg_preamble_len) + 8 * 2 + 4, 0);
      push_op(OP_STOP);
      wait_drained();

      write_csr(CSR_PREAMBLE_LEN, 16'd1);
      write_csr(CSR_POLARITY, {15'($urandom), 1'b1});
      add_traffic(300);
      push_op(OP_STOP);
      wait_drained();

      // largest preamble length setting, aborted part way
      write_csr(CSR_PREAMBLE_LEN, 16'hFFFF);
      write_csr(CSR_POLARITY, {15'($urandom), 1'b0});
      c = make_cmd(OP_START_MSG);
      c.byte_count = 11'd1;
      push_cmd(c);
      push_ticks(100, 5);
      push_op(OP_STOP);
      wait_drained();

      write_csr(CSR_PREAMBLE_LEN, 16'($urandom_range(2, 16)));
      write_csr(CSR_POLARITY, {15'($urandom), 1'b1});
      add_traffic(300);
      push_op(OP_STOP);
      wait_drained();

      // zero length wraps to 65536 preamble bits, so these ticks stay in preamble
      write_csr(CSR_PREAMBLE_LEN, 16'd0);
      write_csr(CSR_POLARITY, {15'($urandom), 1'b0});
      c = make_cmd(OP_START_MSG);
      c.byte_count = 11'd2;
      push_cmd(c);
      push_ticks(100, 1);
      push_op(OP_STOP);
      wait_drained();

      repeat (20) @(posedge clock);
      if (expected_status.size() != 0) begin
         error_count += expected_status.size();
         $display("%0d expected result words never arrived", expected_status.size());
      end
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pbt_pkg.sv
rtl/core/pbt_byte_buf.sv
rtl/core/pager_bit_transmitter.sv
tb/sv/tb_pager_bit_transmitter.sv
